### design/pmra_pkg.sv
// Shared constants and types for the pedestal mean and rms accumulator.
package pmra_pkg;

	localparam int CHANNELS_DEF     = 1152;
	localparam int TIMEBINS_DEF     = 512;
	localparam int GATE_TIMEBIN_DEF = 20;

	localparam int SUM_W  = 21;
	localparam int SQ_W   = 31;
	localparam int CNT_W  = 11;
	localparam int ADC_W  = 10;
	localparam int WORD_W = CNT_W + SQ_W + SUM_W;

	localparam int PROD_W = 42;
	localparam int NUM_W  = PROD_W + 8;
	localparam int DEN_W  = 2 * CNT_W;
	localparam int ROOT_STEPS = NUM_W / 2;
	localparam int STEP_W = 6;

	localparam logic [CNT_W-1:0] COUNT_MAX      = 11'd2047;
	localparam logic [CNT_W-1:0] MAX_EVENTS_RST = 11'd1000;
	localparam logic [13:0]      EMPTY_MEAN     = 14'd16368;
	localparam logic [12:0]      EMPTY_RMS      = 13'd159;
	localparam logic [13:0]      MEAN_SAT       = 14'h3FFF;
	localparam logic [12:0]      RMS_SAT        = 13'd8191;
	localparam logic [5:0]       RMS6_SAT       = 6'h3F;

	localparam logic [1:0] CMD_ACC   = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_GATE_RD,
		ST_GATE_CHK,
		ST_ENT_RD,
		ST_ENT_MOD,
		ST_CLR_WR,
		ST_MUL,
		ST_DIFF,
		ST_DIV_MEAN,
		ST_DIV_VAR,
		ST_SQRT
	} state_t;

endpackage

### design/pmra_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pmra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### design/pedestal_mean_rms_accumulator_unit.sv
// Pedestal mean and rms accumulator: entry store, sequencer, divider and root unit.
//
//  channel  | direction | handshake            | payload
//  request  | in        | start / busy         | cmd, channel, timebin, adc, first_sample
//  result   | out       | done (one cycle)     | mean_fixed, rms_fixed, packed_word, sample_count
//  config   | in        | wr_en                | wr_data (event limit)
//
// Accumulate reads, then modifies its entry, with first_sample after an extra read of the gate
// entry; clear writes it at once. Read: entry read, products, two 50-step shared restoring
// divisions and a 25-step root; a read of an empty entry answers without them.
// The entry store is one RAM with registered read data; an accumulate reads, modifies, writes.
// After reset a clearing pass zeroes CHANNELS*TIMEBINS entries (589824 by default),
// one per cycle, with busy high. The result side cannot stall; done pulses for one cycle.
module pedestal_mean_rms_accumulator_unit #(
	parameter int CHANNELS     = pmra_pkg::CHANNELS_DEF,
	parameter int TIMEBINS     = pmra_pkg::TIMEBINS_DEF,
	parameter int GATE_TIMEBIN = pmra_pkg::GATE_TIMEBIN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [10:0] channel,
	input  logic [8:0]  timebin,
	input  logic [9:0]  adc,
	input  logic        first_sample,
	input  logic        wr_en,
	input  logic [10:0] wr_data,
	output logic        done,
	output logic [13:0] mean_fixed,
	output logic [12:0] rms_fixed,
	output logic [15:0] packed_word,
	output logic [10:0] sample_count
);

	localparam int DEPTH    = CHANNELS * TIMEBINS;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int GATE_OFS = GATE_TIMEBIN % TIMEBINS;
	localparam int SUM_W    = pmra_pkg::SUM_W;
	localparam int SQ_W     = pmra_pkg::SQ_W;
	localparam int CNT_W    = pmra_pkg::CNT_W;
	localparam int NUM_W    = pmra_pkg::NUM_W;
	localparam int DEN_W    = pmra_pkg::DEN_W;
	localparam int PROD_W   = pmra_pkg::PROD_W;
	localparam int STEP_W   = pmra_pkg::STEP_W;

	pmra_pkg::state_t state_q, state_d;

	logic [ADDR_W-1:0] clr_q;
	logic [CNT_W-1:0]  event_limit_q;
	logic              rec_q;
	logic [STEP_W-1:0] step_q;

	logic [1:0]        cmd_q;
	logic              ok_q;
	logic [ADDR_W-1:0] addr_q, gaddr_q;
	logic [SUM_W-1:0]  adc_q;
	logic [SQ_W-1:0]   adc_sq_q;

	logic [CNT_W-1:0]  n_q;
	logic [SUM_W-1:0]  s_q;
	logic [SQ_W-1:0]   sq_q;
	logic [PROD_W-1:0] a_q, b_q;
	logic [DEN_W-1:0]  nn_q;
	logic [NUM_W-1:0]  var_q;

	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q, rem_q;
	logic [NUM_W-1:0]  rv_q, res_q, bit_q;
	logic [13:0]       mean_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [pmra_pkg::WORD_W-1:0] ram_wdata, ram_rdata;

	logic [CNT_W-1:0]  rd_cnt;
	logic [SQ_W-1:0]   rd_sq;
	logic [SUM_W-1:0]  rd_sum;

	logic              accept, ch_ok, tb_ok, acc_ok;
	logic [ADDR_W-1:0] base;
	logic [DEN_W:0]    div_shift;
	logic              div_ge;
	logic [NUM_W-1:0]  root_try;
	logic              root_ge;
	logic [NUM_W-1:0]  root_fin;
	logic [12:0]       rms_fin;

	assign {rd_cnt, rd_sq, rd_sum} = ram_rdata;

	assign accept = start && !busy;
	assign ch_ok  = {2'b0, channel} < 13'(CHANNELS);
	assign tb_ok  = {2'b0, timebin} < 11'(TIMEBINS);
	assign base   = ADDR_W'(channel) * ADDR_W'(TIMEBINS);
	assign acc_ok = ok_q && rec_q && (rd_cnt < pmra_pkg::COUNT_MAX);

	assign div_shift = {rem_q, num_q[NUM_W-1]};
	assign div_ge    = div_shift >= {1'b0, den_q};
	assign root_try  = res_q + bit_q;
	assign root_ge   = rv_q >= root_try;
	assign root_fin  = root_ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);
	assign rms_fin   = (root_fin > NUM_W'(pmra_pkg::RMS_SAT)) ? pmra_pkg::RMS_SAT
	                                                            : root_fin[12:0];

	pmra_ram #(
		.WIDTH(pmra_pkg::WORD_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pmra_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		busy      = 1'b1;
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = '0;
		ram_raddr = addr_q;
		case (state_q)
			pmra_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				if (clr_q == ADDR_W'(DEPTH - 1)) begin
					state_d = pmra_pkg::ST_IDLE;
				end
			end
			pmra_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					case (cmd)
						pmra_pkg::CMD_ACC: begin
							if (first_sample && ch_ok) begin
								state_d = pmra_pkg::ST_GATE_RD;
							end else if (ch_ok && tb_ok) begin
								state_d = pmra_pkg::ST_ENT_RD;
							end
						end
						pmra_pkg::CMD_READ: begin
							state_d = pmra_pkg::ST_ENT_RD;
						end
						pmra_pkg::CMD_CLEAR: begin
							if (ch_ok && tb_ok) begin
								state_d = pmra_pkg::ST_CLR_WR;
							end
						end
						default: state_d = pmra_pkg::ST_IDLE;
					endcase
				end
			end
			pmra_pkg::ST_GATE_RD: begin
				ram_raddr = gaddr_q;
				state_d   = pmra_pkg::ST_GATE_CHK;
			end
			pmra_pkg::ST_GATE_CHK: begin
				state_d = ok_q ? pmra_pkg::ST_ENT_RD : pmra_pkg::ST_IDLE;
			end
			pmra_pkg::ST_ENT_RD: begin
				state_d = pmra_pkg::ST_ENT_MOD;
			end
			pmra_pkg::ST_ENT_MOD: begin
				if (cmd_q == pmra_pkg::CMD_ACC) begin
					ram_we    = acc_ok;
					ram_wdata = {rd_cnt + 1'b1, rd_sq + adc_sq_q, rd_sum + adc_q};
					state_d   = pmra_pkg::ST_IDLE;
				end else if (!ok_q || rd_cnt == '0) begin
					state_d = pmra_pkg::ST_IDLE;
				end else begin
					state_d = pmra_pkg::ST_MUL;
				end
			end
			pmra_pkg::ST_CLR_WR: begin
				ram_we  = 1'b1;
				state_d = pmra_pkg::ST_IDLE;
			end
			pmra_pkg::ST_MUL: begin
				state_d = pmra_pkg::ST_DIFF;
			end
			pmra_pkg::ST_DIFF: begin
				state_d = pmra_pkg::ST_DIV_MEAN;
			end
			pmra_pkg::ST_DIV_MEAN: begin
				if (step_q == STEP_W'(NUM_W - 1)) begin
					state_d = pmra_pkg::ST_DIV_VAR;
				end
			end
			pmra_pkg::ST_DIV_VAR: begin
				if (step_q == STEP_W'(NUM_W - 1)) begin
					state_d = pmra_pkg::ST_SQRT;
				end
			end
			pmra_pkg::ST_SQRT: begin
				if (step_q == STEP_W'(pmra_pkg::ROOT_STEPS - 1)) begin
					state_d = pmra_pkg::ST_IDLE;
				end
			end
			default: state_d = pmra_pkg::ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q         <= '0;
			event_limit_q <= pmra_pkg::MAX_EVENTS_RST;
			rec_q         <= 1'b0;
			step_q        <= '0;
			done          <= 1'b0;
		end else begin
			done <= (state_q == pmra_pkg::ST_ENT_MOD && cmd_q == pmra_pkg::CMD_READ
			         && (!ok_q || rd_cnt == '0))
			        || (state_q == pmra_pkg::ST_SQRT
			            && step_q == STEP_W'(pmra_pkg::ROOT_STEPS - 1));
			if (wr_en) begin
				event_limit_q <= wr_data;
			end
			if (state_q == pmra_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (accept && cmd == pmra_pkg::CMD_ACC && first_sample && !ch_ok) begin
				rec_q <= 1'b0;
			end
			if (state_q == pmra_pkg::ST_GATE_CHK) begin
				rec_q <= rd_cnt <= event_limit_q;
			end
			if (state_q == pmra_pkg::ST_DIV_MEAN || state_q == pmra_pkg::ST_DIV_VAR) begin
				step_q <= (step_q == STEP_W'(NUM_W - 1)) ? '0 : step_q + 1'b1;
			end else if (state_q == pmra_pkg::ST_SQRT) begin
				step_q <= (step_q == STEP_W'(pmra_pkg::ROOT_STEPS - 1)) ? '0 : step_q + 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd;
			ok_q     <= ch_ok && tb_ok;
			addr_q   <= base + ADDR_W'(timebin);
			gaddr_q  <= base + ADDR_W'(GATE_OFS);
			adc_q    <= SUM_W'(adc);
			adc_sq_q <= SQ_W'(adc) * SQ_W'(adc);
		end
		case (state_q)
			pmra_pkg::ST_ENT_MOD: begin
				n_q  <= rd_cnt;
				s_q  <= rd_sum;
				sq_q <= rd_sq;
				if (cmd_q == pmra_pkg::CMD_READ && (!ok_q || rd_cnt == '0)) begin
					mean_fixed   <= pmra_pkg::EMPTY_MEAN;
					rms_fixed    <= pmra_pkg::EMPTY_RMS;
					packed_word  <= {pmra_pkg::RMS6_SAT, pmra_pkg::EMPTY_MEAN[13:4]};
					sample_count <= '0;
				end
			end
			pmra_pkg::ST_MUL: begin
				a_q  <= PROD_W'(n_q) * PROD_W'(sq_q);
				b_q  <= PROD_W'(s_q) * PROD_W'(s_q);
				nn_q <= DEN_W'(n_q) * DEN_W'(n_q);
			end
			pmra_pkg::ST_DIFF: begin
				// clamp a negative variance to zero
				var_q <= (a_q >= b_q) ? {a_q - b_q, 8'b0} : '0;
				num_q <= NUM_W'({s_q, 4'b0});
				den_q <= DEN_W'(n_q);
				rem_q <= '0;
			end
			pmra_pkg::ST_DIV_MEAN, pmra_pkg::ST_DIV_VAR: begin
				if (state_q == pmra_pkg::ST_DIV_MEAN && step_q == STEP_W'(NUM_W - 1)) begin
					// take the mean, hand the divider over to the variance
					mean_q <= ({num_q[NUM_W-2:0], div_ge} > NUM_W'(pmra_pkg::MEAN_SAT))
					          ? pmra_pkg::MEAN_SAT : num_q[12:0] << 1 | 14'(div_ge);
					num_q  <= var_q;
					den_q  <= nn_q;
					rem_q  <= '0;
				end else begin
					rem_q <= div_ge ? DEN_W'(div_shift - {1'b0, den_q})
					                : div_shift[DEN_W-1:0];
					num_q <= {num_q[NUM_W-2:0], div_ge};
					if (step_q == STEP_W'(NUM_W - 1)) begin
						rv_q  <= {num_q[NUM_W-2:0], div_ge};
						res_q <= '0;
						bit_q <= NUM_W'(1) << (NUM_W - 2);
					end
				end
			end
			pmra_pkg::ST_SQRT: begin
				if (root_ge) begin
					rv_q <= rv_q - root_try;
				end
				res_q <= root_fin;
				bit_q <= bit_q >> 2;
				if (step_q == STEP_W'(pmra_pkg::ROOT_STEPS - 1)) begin
					mean_fixed   <= mean_q;
					rms_fixed    <= rms_fin;
					packed_word  <= {(rms_fin > 13'(pmra_pkg::RMS6_SAT)) ? pmra_pkg::RMS6_SAT
					                                                     : rms_fin[5:0],
					                 mean_q[13:4]};
					sample_count <= n_q;
				end
			end
			default: begin
			end
		endcase
	end

	a_idle_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pmra_pkg::ST_CLEAR && ram_we) |-> ram_wdata == '0)
		else $error("clearing pass writes nonzero data");

	a_packed_mean: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> packed_word[9:0] == mean_fixed[13:4])
		else $error("packed word mean field mismatch");

	a_no_write_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && state_q == pmra_pkg::ST_ENT_MOD) |-> cmd_q == pmra_pkg::CMD_ACC && ok_q)
		else $error("store written on a read or out-of-range request");

endmodule

### sim/tb_pedestal_mean_rms_accumulator_unit.sv
// Testbench for the pedestal mean and rms accumulator: directed table, random records, scoreboard.
`timescale 1ns / 100ps

module tb_pedestal_mean_rms_accumulator_unit;

	localparam int NCH = pmra_pkg::CHANNELS_DEF;
	localparam int NTB = pmra_pkg::TIMEBINS_DEF;
	localparam int GATE_TB = pmra_pkg::GATE_TIMEBIN_DEF % NTB;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]  cmd;
		logic [10:0] ch;
		logic [8:0]  tb;
		logic [9:0]  adc;
		logic        first;
	} request_t;

	typedef struct {
		logic [13:0] mean;
		logic [12:0] rms;
		logic [15:0] word;
		logic [10:0] count;
	} stats_t;

	typedef struct {
		request_t req;
		bit       typed;
		stats_t   res;
	} table_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  cmd = pmra_pkg::CMD_ACC;
	logic [10:0] channel = '0;
	logic [8:0]  timebin = '0;
	logic [9:0]  adc = '0;
	logic        first_sample = 1'b0;
	logic        wr_en = 1'b0;
	logic [10:0] wr_data = '0;
	logic        done;
	logic [13:0] mean_fixed;
	logic [12:0] rms_fixed;
	logic [15:0] packed_word;
	logic [10:0] sample_count;

	// predictor state
	logic [20:0] sum_mem [int unsigned];
	logic [30:0] sq_mem  [int unsigned];
	logic [10:0] cnt_mem [int unsigned];
	bit          rec_taken;
	logic [10:0] event_limit;

	stats_t stats_expected[$];
	int     mismatches;

	pedestal_mean_rms_accumulator_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .channel(channel), .timebin(timebin), .adc(adc),
		.first_sample(first_sample), .wr_en(wr_en), .wr_data(wr_data),
		.done(done), .mean_fixed(mean_fixed), .rms_fixed(rms_fixed),
		.packed_word(packed_word), .sample_count(sample_count)
	);

	always #10 clk = ~clk;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned root;
		longint unsigned b;
		root = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= root + b) begin
				v = v - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	function automatic logic [10:0] count_at(int unsigned i);
		return cnt_mem.exists(i) ? cnt_mem[i] : 11'd0;
	endfunction

	// Update the entry model for one request; return 1 with stats for a read.
	function automatic bit predict_request(request_t r, output stats_t s);
		bit ch_ok, ok;
		int unsigned i;
		longint unsigned n, sm, sq, a, b, m, rt;
		ch_ok = r.ch < NCH;
		ok = ch_ok && (r.tb < NTB);
		i = ok ? r.ch * NTB + r.tb : 0;
		s = '{default: '0};
		case (r.cmd)
			pmra_pkg::CMD_ACC: begin
				if (r.first)
					rec_taken = ch_ok && (count_at(r.ch * NTB + GATE_TB) <= event_limit);
				if (ok && rec_taken && count_at(i) < pmra_pkg::COUNT_MAX) begin
					sum_mem[i] = (sum_mem.exists(i) ? sum_mem[i] : 21'd0) + 21'(r.adc);
					sq_mem[i] = (sq_mem.exists(i) ? sq_mem[i] : 31'd0)
						+ 31'(r.adc) * 31'(r.adc);
					cnt_mem[i] = count_at(i) + 11'd1;
				end
				return 0;
			end
			pmra_pkg::CMD_CLEAR: begin
				if (ok) begin
					sum_mem[i] = '0;
					sq_mem[i] = '0;
					cnt_mem[i] = '0;
				end
				return 0;
			end
			pmra_pkg::CMD_READ: begin
				n = ok ? 64'(count_at(i)) : 64'd0;
				if (n == 0) begin
					s = '{pmra_pkg::EMPTY_MEAN, pmra_pkg::EMPTY_RMS, 16'hFFFF, 11'd0};
				end else begin
					sm = 64'(sum_mem[i]);
					sq = 64'(sq_mem[i]);
					a = n * sq;
					b = sm * sm;
					m = (sm * 16) / n;
					if (m > pmra_pkg::MEAN_SAT) m = 64'(pmra_pkg::MEAN_SAT);
					rt = (a < b) ? 0 : int_sqrt(((a - b) * 256) / (n * n));
					if (rt > pmra_pkg::RMS_SAT) rt = 64'(pmra_pkg::RMS_SAT);
					s.mean = m[13:0];
					s.rms = rt[12:0];
					s.count = n[10:0];
					s.word = {(rt > pmra_pkg::RMS6_SAT) ? pmra_pkg::RMS6_SAT : rt[5:0], m[13:4]};
				end
				return 1;
			end
			default: return 0;
		endcase
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(99);
		if (p < 55) return 0;
		if (p < 90) return $urandom_range(3, 1);
		return $urandom_range(60, 10);
	endfunction

	// Issue one request, wait for acceptance, record the expectation.
	task automatic send(request_t r, int gap, bit typed = 0, stats_t want = '{default: '0});
		stats_t s;
		cmd <= r.cmd;
		channel <= r.ch;
		timebin <= r.tb;
		adc <= r.adc;
		first_sample <= r.first;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (predict_request(r, s)) begin
			if (typed)
				stats_expected.push_back(want);
			else
				stats_expected.push_back(s);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (stats_expected.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic set_limit(logic [10:0] v);
		drain();
		wr_en <= 1'b1;
		wr_data <= v;
		@(posedge clk);
		wr_en <= 1'b0;
		event_limit = v;
		@(posedge clk);
	endtask

	function automatic logic [10:0] rand_channel();
		int p;
		p = $urandom_range(99);
		if (p < 70) return 11'($urandom_range(3));
		if (p < 80) return 11'(NCH - 1);
		return 11'($urandom_range(2047));
	endfunction

	function automatic logic [8:0] rand_timebin();
		int p;
		p = $urandom_range(99);
		if (p < 35) return 9'(GATE_TB);
		if (p < 80) return 9'($urandom_range(2));
		if (p < 88) return 9'(NTB - 1);
		return 9'($urandom_range(511));
	endfunction

	// Mostly well-formed records (first sample, then samples of that channel), some reads,
	// some clears and stray commands.
	task automatic random_phase(int items);
		request_t r;
		int left, k, rec;
		left = items;
		while (left > 0) begin
			k = $urandom_range(99);
			if (k < 60) begin
				r.cmd = pmra_pkg::CMD_ACC;
				r.ch = rand_channel();
				rec = $urandom_range(6, 1);
				for (int j = 0; j < rec && left > 0; j++) begin
					r.tb = rand_timebin();
					r.adc = ($urandom_range(3) == 0) ? 10'($urandom_range(1023))
						: 10'($urandom_range(120, 90));
					r.first = (j == 0) ? 1'b1 : ($urandom_range(15) == 0);
					send(r, pick_gap());
					left--;
				end
			end else begin
				r.cmd = (k < 88) ? pmra_pkg::CMD_READ
					: (k < 96) ? pmra_pkg::CMD_CLEAR : CMD_UNUSED;
				r.ch = rand_channel();
				r.tb = rand_timebin();
				r.adc = 10'($urandom_range(1023));
				r.first = 1'($urandom_range(1));
				send(r, pick_gap());
				left--;
			end
			if (left == items / 2) drain();
		end
	endtask

	localparam stats_t EMPTY = '{pmra_pkg::EMPTY_MEAN, pmra_pkg::EMPTY_RMS, 16'hFFFF, 11'd0};
	localparam stats_t NONE = '{default: '0};

	table_row_t directed[] = '{
		'{'{pmra_pkg::CMD_READ, 11'd0, 9'd0, 10'd0, 1'b0}, 1, EMPTY},
		'{'{pmra_pkg::CMD_READ, 11'd2047, 9'd511, 10'd0, 1'b0}, 1, EMPTY},
		'{'{CMD_UNUSED, 11'd0, 9'd0, 10'd1023, 1'b1}, 0, NONE},
		'{'{pmra_pkg::CMD_ACC, 11'd0, 9'd0, 10'd1023, 1'b1}, 0, NONE},
		'{'{pmra_pkg::CMD_ACC, 11'd0, 9'd0, 10'd0, 1'b0}, 0, NONE},
		'{'{pmra_pkg::CMD_READ, 11'd0, 9'd0, 10'd0, 1'b0}, 0, NONE},
		'{'{pmra_pkg::CMD_ACC, 11'd1151, 9'd511, 10'd1023, 1'b1}, 0, NONE},
		'{'{pmra_pkg::CMD_READ, 11'd1151, 9'd511, 10'd0, 1'b1}, 1,
			'{14'd16368, 13'd0, 16'd1023, 11'd1}},
		'{'{pmra_pkg::CMD_CLEAR, 11'd0, 9'd0, 10'd0, 1'b0}, 0, NONE},
		'{'{pmra_pkg::CMD_READ, 11'd0, 9'd0, 10'd0, 1'b0}, 1, EMPTY},
		'{'{pmra_pkg::CMD_ACC, 11'd2000, 9'd3, 10'd5, 1'b1}, 0, NONE},
		'{'{pmra_pkg::CMD_ACC, 11'd3, 9'd4, 10'd5, 1'b0}, 0, NONE},
		'{'{pmra_pkg::CMD_READ, 11'd3, 9'd4, 10'd0, 1'b0}, 1, EMPTY},
		'{'{pmra_pkg::CMD_CLEAR, 11'd2000, 9'd4, 10'd0, 1'b0}, 0, NONE},
		'{'{pmra_pkg::CMD_ACC, 11'd7, 9'd9, 10'd0, 1'b1}, 0, NONE},
		'{'{pmra_pkg::CMD_READ, 11'd7, 9'd9, 10'd0, 1'b0}, 1, '{14'd0, 13'd0, 16'd0, 11'd1}},
		'{'{pmra_pkg::CMD_ACC, 11'd7, 9'd9, 10'd682, 1'b0}, 0, NONE},
		'{'{pmra_pkg::CMD_ACC, 11'd7, 9'd20, 10'd341, 1'b0}, 0, NONE},
		'{'{pmra_pkg::CMD_READ, 11'd7, 9'd9, 10'd0, 1'b0}, 0, NONE},
		'{'{pmra_pkg::CMD_READ, 11'd7, 9'd20, 10'd0, 1'b0}, 0, NONE}
	};

	always @(posedge clk) begin
		stats_t e;
		if (done) begin
			if (stats_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result mean=%0d rms=%0d word=%h count=%0d",
						mean_fixed, rms_fixed, packed_word, sample_count);
			end else begin
				e = stats_expected.pop_front();
				if (mean_fixed !== e.mean || rms_fixed !== e.rms ||
					packed_word !== e.word || sample_count !== e.count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp %0d/%0d/%h/%0d got %0d/%0d/%h/%0d",
							e.mean, e.rms, e.word, e.count,
							mean_fixed, rms_fixed, packed_word, sample_count);
				end
			end
		end
	end

	initial begin
		#80_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		request_t r;
		mismatches = 0;
		rec_taken = 0;
		event_limit = pmra_pkg::MAX_EVENTS_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send(directed[i].req, pick_gap(), directed[i].typed, directed[i].res);

		set_limit(11'd1);
		random_phase(250);

		// top limit: a long record into the gate entry, then a fresh record is still taken
		set_limit(11'd2046);
		r = '{pmra_pkg::CMD_ACC, 11'd5, 9'(GATE_TB), 10'd1023, 1'b1};
		send(r, 0);
		r.first = 1'b0;
		repeat (60) begin
			r.adc = ($urandom_range(1) != 0) ? 10'd1023 : 10'($urandom_range(1023));
			send(r, 0);
		end
		r.first = 1'b1;
		send(r, 0);
		r.cmd = pmra_pkg::CMD_READ;
		send(r, 3);
		random_phase(200);

		set_limit(11'h555);
		random_phase(50);
		set_limit(11'd3);
		random_phase(230);

		drain();
		repeat (200) @(posedge clk);
		if (mismatches == 0 && stats_expected.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
